/* hw/rtl/shb3_pkg.sv */
// Shared constants, types and helper functions for the degree-3 SH basis block.
package shb3_pkg;

  localparam int DIR_WIDTH     = 16;
  localparam int OUT_FRAC_BITS = 14;
  localparam int NUM_COEF      = 16;

  // Q30 basis constants
  localparam logic [32:0] K_DC  = 33'd302896976;
  localparam logic [32:0] K_C1  = 33'd524632952;
  localparam logic [32:0] K_C2A = 33'd1173114945;
  localparam logic [32:0] K_C2C = 33'd338649115;
  localparam logic [32:0] K_C2E = 33'd586557472;
  localparam logic [32:0] K_C3A = 33'd633554480;
  localparam logic [32:0] K_C3B = 33'd3103770403;
  localparam logic [32:0] K_C3C = 33'd490749190;
  localparam logic [32:0] K_C3D = 33'd400695036;
  localparam logic [32:0] K_C3F = 33'd1551885201;

  // Normalized direction handed from the front end to the basis evaluator
  typedef struct packed {
    logic        err;
    logic [30:0] ux;   // magnitude, Q30, at most 2^30
    logic [30:0] uy;
    logic [30:0] uz;
    logic        nx;
    logic        ny;
    logic        nz;
  } shb3_unit_t;

  // Signed Q30 product, rounded half away from zero
  function automatic logic signed [39:0] rmul(input logic signed [39:0] a,
                                              input logic signed [39:0] b);
    logic        ng;
    logic [39:0] ma;
    logic [39:0] mb;
    logic [79:0] p;
    logic [79:0] r;
    ng = a[39] ^ b[39];
    ma = a[39] ? 40'(-a) : 40'(a);
    mb = b[39] ? 40'(-b) : 40'(b);
    p  = 80'(ma) * 80'(mb);
    r  = (p + 80'(64'd1 << 29)) >> 30;
    rmul = ng ? -$signed(r[39:0]) : $signed(r[39:0]);
  endfunction

  // Q30 to output format, rounded and saturated
  function automatic logic [15:0] to_out(input logic signed [39:0] q);
    logic [39:0] m;
    logic [39:0] r;
    m = q[39] ? 40'(-q) : 40'(q);
    r = (m + 40'(40'd1 << (29 - OUT_FRAC_BITS))) >> (30 - OUT_FRAC_BITS);
    if (q[39]) begin
      to_out = (r > 40'd32768) ? 16'h8000 : 16'(-r);
    end else begin
      to_out = (r > 40'd32767) ? 16'h7fff : r[15:0];
    end
  endfunction

endpackage

/* hw/rtl/shb3_norm.sv */
// Front end: magnitude, scaling, integer square root and per-axis division pipeline.
module shb3_norm (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               adv,
  input  logic                               in_vld,
  input  logic signed [shb3_pkg::DIR_WIDTH-1:0] dx,
  input  logic signed [shb3_pkg::DIR_WIDTH-1:0] dy,
  input  logic signed [shb3_pkg::DIR_WIDTH-1:0] dz,
  output logic                               out_vld,
  output shb3_pkg::shb3_unit_t               unit
);
  localparam int W   = shb3_pkg::DIR_WIDTH;
  localparam int SQS = 31;  // sqrt steps: result bits of floor(sqrt(n2<<28)), n2 < 2^34
  localparam int DVS = 31;  // quotient bits
  localparam int NS  = 2 + SQS + DVS;

  // stage A: magnitudes
  logic [W-1:0] ma_r [3];
  logic         na_r [3];
  logic         va_r;
  logic         za_r;
  // stage B: normalized magnitudes, 16 bits
  logic [15:0]  mb_r [3];
  logic         nb_r [3];
  logic         vb_r;
  logic         zb_r;

  // sqrt / divide pipeline arrays
  logic         v_r   [NS];
  logic         z_r   [NS];
  logic [15:0]  m_r   [NS][3];
  logic         n_r   [NS][3];
  logic [63:0]  rem_r [NS];
  logic [30:0]  res_r [NS];
  logic [61:0]  dr_r  [NS][3];
  logic [30:0]  q_r   [NS][3];

  logic [W-1:0] mag_nxt [3];
  logic [W-1:0] mx;
  logic [4:0]   lz;
  logic [15:0]  mb_nxt [3];

  // take magnitudes
  always_comb begin
    logic signed [W-1:0] d [3];
    d[0] = dx; d[1] = dy; d[2] = dz;
    for (int i = 0; i < 3; i++) begin
      mag_nxt[i] = d[i][W-1] ? W'(-d[i]) : W'(d[i]);
    end
  end

  // find shift so that largest lands in [2^15, 2^16)
  always_comb begin
    logic [W-1:0] t;
    mx = ma_r[0];
    if (ma_r[1] > mx) mx = ma_r[1];
    if (ma_r[2] > mx) mx = ma_r[2];
    lz = '0;
    t  = mx;
    for (int b = W - 1; b >= 0; b--) begin
      if (t[b] && lz == 5'd0) lz = 5'(b + 1);
    end
    for (int i = 0; i < 3; i++) begin
      if (lz >= 5'd16) begin
        mb_nxt[i] = 16'(ma_r[i] >> (lz - 5'd16));
      end else begin
        mb_nxt[i] = 16'(32'(ma_r[i]) << (5'd16 - lz));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else if (adv) begin
      va_r <= in_vld;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      za_r <= (dx == '0) && (dy == '0) && (dz == '0);
      na_r[0] <= dx[W-1]; na_r[1] <= dy[W-1]; na_r[2] <= dz[W-1];
      for (int i = 0; i < 3; i++) ma_r[i] <= mag_nxt[i];
      zb_r <= za_r;
      for (int i = 0; i < 3; i++) begin
        mb_r[i] <= mb_nxt[i];
        nb_r[i] <= na_r[i];
      end
    end
  end

  // sum of squares, then one sqrt bit per stage, then one quotient bit per stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NS; s++) v_r[s] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= vb_r;
      for (int s = 1; s < NS; s++) v_r[s] <= v_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // entry: n2 << 28
      z_r[0]   <= zb_r;
      rem_r[0] <= 64'({30'd0, 34'(32'(mb_r[0]) * 32'(mb_r[0])) +
                  34'(32'(mb_r[1]) * 32'(mb_r[1])) + 34'(32'(mb_r[2]) * 32'(mb_r[2]))}) << 28;
      res_r[0] <= '0;
      for (int i = 0; i < 3; i++) begin
        m_r[0][i]  <= mb_r[i];
        n_r[0][i]  <= nb_r[i];
        dr_r[0][i] <= '0;
        q_r[0][i]  <= '0;
      end
      for (int s = 1; s < NS; s++) begin
        z_r[s] <= z_r[s-1];
        for (int i = 0; i < 3; i++) begin
          m_r[s][i] <= m_r[s-1][i];
          n_r[s][i] <= n_r[s-1][i];
        end
        if (s <= SQS) begin
          // restoring sqrt, bit position SQS-s
          logic [63:0] trial;
          logic [30:0] cand;
          cand  = res_r[s-1] | 31'(31'd1 << (SQS - s));
          trial = 64'(cand) * 64'(cand);
          res_r[s] <= (trial <= rem_r[s-1]) ? cand : res_r[s-1];
          rem_r[s] <= rem_r[s-1];
          for (int i = 0; i < 3; i++) begin
            dr_r[s][i] <= '0;
            q_r[s][i]  <= '0;
          end
        end else if (s == SQS + 1) begin
          // dividend m<<44 + s/2 held as running remainder; quotient fits 31 bits
          res_r[s] <= res_r[s-1];
          rem_r[s] <= rem_r[s-1];
          for (int i = 0; i < 3; i++) begin
            logic [62:0] dvd;
            logic [62:0] dvs;
            dvd = (63'(m_r[s-1][i]) << 44) + 63'(res_r[s-1] >> 1);
            dvs = 63'(res_r[s-1]) << 30;
            dr_r[s][i] <= (dvd >= dvs) ? 62'(dvd - dvs) : 62'(dvd);
            q_r[s][i]  <= (dvd >= dvs) ? 31'(31'd1 << 30) : 31'd0;
          end
        end else begin
          res_r[s] <= res_r[s-1];
          rem_r[s] <= rem_r[s-1];
          for (int i = 0; i < 3; i++) begin
            logic [62:0] dvs;
            dvs = 63'(res_r[s-1]) << (NS - 1 - s);
            if (63'(dr_r[s-1][i]) >= dvs) begin
              dr_r[s][i] <= 62'(63'(dr_r[s-1][i]) - dvs);
              q_r[s][i]  <= q_r[s-1][i] | 31'(31'd1 << (NS - 1 - s));
            end else begin
              dr_r[s][i] <= dr_r[s-1][i];
              q_r[s][i]  <= q_r[s-1][i];
            end
          end
        end
      end
    end
  end

  // clamp to one and hand over
  always_comb begin
    logic [30:0] c [3];
    for (int i = 0; i < 3; i++) begin
      c[i] = (q_r[NS-1][i] > 31'h4000_0000) ? 31'h4000_0000 : q_r[NS-1][i];
    end
    out_vld   = v_r[NS-1];
    unit.err  = z_r[NS-1];
    unit.ux   = c[0];
    unit.uy   = c[1];
    unit.uz   = c[2];
    unit.nx   = n_r[NS-1][0];
    unit.ny   = n_r[NS-1][1];
    unit.nz   = n_r[NS-1][2];
  end
endmodule

/* hw/rtl/shb3_basis.sv */
// Basis evaluator: squares, polynomials and constant products over registered stages.
module shb3_basis (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 in_vld,
  input  shb3_pkg::shb3_unit_t unit,
  input  logic [1:0]           deg,
  output logic                 out_vld,
  output logic                 out_err,
  output logic [15:0]          vals [shb3_pkg::NUM_COEF]
);
  typedef logic signed [39:0] q_t;

  logic v1_r, v2_r, v3_r, v4_r;
  logic e1_r, e2_r, e3_r, e4_r;
  logic [1:0] d1_r, d2_r, d3_r, d4_r;
  q_t x1_r, y1_r, z1_r;
  q_t x2_r, y2_r, z2_r, xx2_r, yy2_r, zz2_r, xy2_r, yz2_r, xz2_r;
  q_t p3_r [16];
  q_t b4_r [16];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_vld; v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // signed components
      e1_r <= unit.err; d1_r <= deg;
      x1_r <= unit.nx ? -q_t'(unit.ux) : q_t'(unit.ux);
      y1_r <= unit.ny ? -q_t'(unit.uy) : q_t'(unit.uy);
      z1_r <= unit.nz ? -q_t'(unit.uz) : q_t'(unit.uz);
      // pair products
      e2_r <= e1_r; d2_r <= d1_r;
      x2_r <= x1_r; y2_r <= y1_r; z2_r <= z1_r;
      xx2_r <= shb3_pkg::rmul(x1_r, x1_r);
      yy2_r <= shb3_pkg::rmul(y1_r, y1_r);
      zz2_r <= shb3_pkg::rmul(z1_r, z1_r);
      xy2_r <= shb3_pkg::rmul(x1_r, y1_r);
      yz2_r <= shb3_pkg::rmul(y1_r, z1_r);
      xz2_r <= shb3_pkg::rmul(x1_r, z1_r);
      // inner polynomials
      e3_r <= e2_r; d3_r <= d2_r;
      p3_r[0]  <= '0;
      p3_r[1]  <= y2_r;
      p3_r[2]  <= z2_r;
      p3_r[3]  <= x2_r;
      p3_r[4]  <= xy2_r;
      p3_r[5]  <= yz2_r;
      p3_r[6]  <= 2 * zz2_r - xx2_r - yy2_r;
      p3_r[7]  <= xz2_r;
      p3_r[8]  <= xx2_r - yy2_r;
      p3_r[9]  <= shb3_pkg::rmul(y2_r, 3 * xx2_r - yy2_r);
      p3_r[10] <= shb3_pkg::rmul(xy2_r, z2_r);
      p3_r[11] <= shb3_pkg::rmul(y2_r, 4 * zz2_r - xx2_r - yy2_r);
      p3_r[12] <= shb3_pkg::rmul(z2_r, 2 * zz2_r - 3 * xx2_r - 3 * yy2_r);
      p3_r[13] <= shb3_pkg::rmul(x2_r, 4 * zz2_r - xx2_r - yy2_r);
      p3_r[14] <= shb3_pkg::rmul(z2_r, xx2_r - yy2_r);
      p3_r[15] <= shb3_pkg::rmul(x2_r, xx2_r - 3 * yy2_r);
      // constant products
      e4_r <= e3_r; d4_r <= d3_r;
      b4_r[0]  <= q_t'(shb3_pkg::K_DC);
      b4_r[1]  <= -shb3_pkg::rmul(q_t'(shb3_pkg::K_C1), p3_r[1]);
      b4_r[2]  <= shb3_pkg::rmul(q_t'(shb3_pkg::K_C1), p3_r[2]);
      b4_r[3]  <= -shb3_pkg::rmul(q_t'(shb3_pkg::K_C1), p3_r[3]);
      b4_r[4]  <= shb3_pkg::rmul(q_t'(shb3_pkg::K_C2A), p3_r[4]);
      b4_r[5]  <= -shb3_pkg::rmul(q_t'(shb3_pkg::K_C2A), p3_r[5]);
      b4_r[6]  <= shb3_pkg::rmul(q_t'(shb3_pkg::K_C2C), p3_r[6]);
      b4_r[7]  <= -shb3_pkg::rmul(q_t'(shb3_pkg::K_C2A), p3_r[7]);
      b4_r[8]  <= shb3_pkg::rmul(q_t'(shb3_pkg::K_C2E), p3_r[8]);
      b4_r[9]  <= -shb3_pkg::rmul(q_t'(shb3_pkg::K_C3A), p3_r[9]);
      b4_r[10] <= shb3_pkg::rmul(q_t'(shb3_pkg::K_C3B), p3_r[10]);
      b4_r[11] <= -shb3_pkg::rmul(q_t'(shb3_pkg::K_C3C), p3_r[11]);
      b4_r[12] <= shb3_pkg::rmul(q_t'(shb3_pkg::K_C3D), p3_r[12]);
      b4_r[13] <= -shb3_pkg::rmul(q_t'(shb3_pkg::K_C3C), p3_r[13]);
      b4_r[14] <= shb3_pkg::rmul(q_t'(shb3_pkg::K_C3F), p3_r[14]);
      b4_r[15] <= -shb3_pkg::rmul(q_t'(shb3_pkg::K_C3A), p3_r[15]);
    end
  end

  // mask by degree and convert
  always_comb begin
    out_vld = v4_r;
    out_err = e4_r;
    for (int i = 0; i < 16; i++) begin
      logic [1:0] band;
      band = (i >= 9) ? 2'd3 : (i >= 4) ? 2'd2 : (i >= 1) ? 2'd1 : 2'd0;
      vals[i] = (band <= d4_r) ? shb3_pkg::to_out(b4_r[i]) : 16'd0;
    end
  end
endmodule

/* hw/rtl/sh_basis_degree3_eval.sv */
// Top level of the degree-3 real spherical-harmonic basis evaluator.
// Each accepted direction yields sixteen words, coefficient 0 to 15, last
// marked; the zero vector yields one word with dir_error set. The output
// drains one word per cycle while out_ready is high; a new direction is
// taken while the previous run drains, and the normalize/evaluate pipeline
// (seventy stages: two for scaling, one for the sum of squares, 31
// square-root and 32 divide steps, four for the basis) holds several
// directions in flight. A run is loaded into the output buffer register
// from the last basis stage.
module sh_basis_degree3_eval (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [1:0]                             cfg_sh_degree,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [shb3_pkg::DIR_WIDTH-1:0]  in_dir_x,
  input  logic signed [shb3_pkg::DIR_WIDTH-1:0]  in_dir_y,
  input  logic signed [shb3_pkg::DIR_WIDTH-1:0]  in_dir_z,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [3:0]                             out_coef_index,
  output logic signed [15:0]                     out_basis_value,
  output logic                                   out_dir_error,
  output logic                                   out_last
);
  logic [1:0] deg_r;
  logic       adv;
  logic       nv;
  logic       bv;
  logic       be;
  shb3_pkg::shb3_unit_t unit;
  logic [15:0] vals [shb3_pkg::NUM_COEF];

  // output run buffer
  logic        full_r;
  logic        err_r;
  logic [3:0]  idx_r;
  logic [15:0] buf_r [shb3_pkg::NUM_COEF];
  logic        done;

  always_ff @(posedge clk) begin
    if (!rst_n) deg_r <= 2'd3;
    else if (cfg_we) deg_r <= cfg_sh_degree;
  end

  assign out_valid       = full_r;
  assign out_coef_index  = idx_r;
  assign out_basis_value = buf_r[idx_r];
  assign out_dir_error   = err_r;
  assign out_last        = err_r || (idx_r == 4'd15);
  assign done            = full_r && out_ready && out_last;
  // advance the pipeline unless a finished run waits on a full buffer
  assign adv      = !bv || !full_r || done;
  assign in_ready = adv;

  shb3_norm u_norm (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_vld(in_valid && in_ready),
    .dx(in_dir_x), .dy(in_dir_y), .dz(in_dir_z), .out_vld(nv), .unit(unit)
  );

  shb3_basis u_basis (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_vld(nv), .unit(unit), .deg(deg_r),
    .out_vld(bv), .out_err(be), .vals(vals)
  );

  // load a run, step through it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
      idx_r  <= '0;
    end else if (adv && bv) begin
      full_r <= 1'b1;
      idx_r  <= '0;
    end else if (full_r && out_ready) begin
      if (out_last) full_r <= 1'b0;
      idx_r <= idx_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && bv) begin
      err_r <= be;
      for (int i = 0; i < shb3_pkg::NUM_COEF; i++) buf_r[i] <= be ? 16'd0 : vals[i];
    end
  end
endmodule

/* tb/sh_basis_checker.sv */
// Checker for the SH basis evaluator: predicts every output word and compares it.
`timescale 1ns / 1ps
module sh_basis_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_sh_degree,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [15:0] in_dir_x,
  input  logic signed [15:0] in_dir_y,
  input  logic signed [15:0] in_dir_z,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [3:0]         out_coef_index,
  input  logic signed [15:0] out_basis_value,
  input  logic               out_dir_error,
  input  logic               out_last,
  output int                 fail_count,
  output int                 pending_words
);

  typedef struct packed {
    logic [3:0]  idx;
    logic [15:0] val;
    logic        err;
    logic        last;
  } sh_word_t;

  sh_word_t    basis_queue[$];
  logic [1:0]  degree_shadow;

  localparam longint K_DC  = 64'd302896976;
  localparam longint K_C1  = 64'd524632952;
  localparam longint K_C2A = 64'd1173114945;
  localparam longint K_C2C = 64'd338649115;
  localparam longint K_C2E = 64'd586557472;
  localparam longint K_C3A = 64'd633554480;
  localparam longint K_C3B = 64'd3103770403;
  localparam longint K_C3C = 64'd490749190;
  localparam longint K_C3D = 64'd400695036;
  localparam longint K_C3F = 64'd1551885201;

  assign pending_words = basis_queue.size();

  // Q30 product rounded half away from zero
  function automatic longint q30_mul(longint a, longint b);
    logic             ng;
    longint unsigned  p;
    ng = (a < 0) != (b < 0);
    p  = longint'(a < 0 ? -a : a) * longint'(b < 0 ? -b : b);
    p  = (p + (64'd1 << 29)) >> 30;
    return ng ? -longint'(p) : longint'(p);
  endfunction

  function automatic logic [15:0] q30_to_q14(longint q);
    longint unsigned m;
    m = ((q < 0 ? -q : q) + (64'd1 << 15)) >> 16;
    if (q < 0) return (m > 32768) ? 16'h8000 : 16'(-longint'(m));
    return (m > 32767) ? 16'h7fff : m[15:0];
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bt;
    res = 0;
    bt  = 64'd1 << 62;
    while (bt > v) bt >>= 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v   -= res + bt;
        res  = (res >> 1) + bt;
      end else begin
        res >>= 1;
      end
      bt >>= 2;
    end
    return res;
  endfunction

  // Normalize the direction and queue its basis words
  task automatic predict_basis(logic signed [15:0] dx, logic signed [15:0] dy,
                               logic signed [15:0] dz);
    longint unsigned mg[3];
    longint unsigned mx, n2, s, q;
    logic            ng[3];
    longint          u[3], b[16];
    longint          x, y, z, xx, yy, zz, t4;
    logic signed [15:0] c[3];
    sh_word_t        w;
    c = '{dx, dy, dz};
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      ng[i] = c[i] < 0;
      mg[i] = ng[i] ? longint'(-int'(c[i])) : longint'(c[i]);
      if (mg[i] > mx) mx = mg[i];
    end
    if (mx == 0) begin
      w = '{idx: 4'd0, val: 16'd0, err: 1'b1, last: 1'b1};
      basis_queue.push_back(w);
      return;
    end
    while (mx < 32768) begin
      mx <<= 1;
      for (int i = 0; i < 3; i++) mg[i] <<= 1;
    end
    while (mx >= 65536) begin
      mx >>= 1;
      for (int i = 0; i < 3; i++) mg[i] >>= 1;
    end
    n2 = mg[0] * mg[0] + mg[1] * mg[1] + mg[2] * mg[2];
    s  = int_sqrt(n2 << 28);
    for (int i = 0; i < 3; i++) begin
      q = ((mg[i] << 44) + (s >> 1)) / s;
      if (q > (64'd1 << 30)) q = 64'd1 << 30;
      u[i] = ng[i] ? -longint'(q) : longint'(q);
    end
    x = u[0]; y = u[1]; z = u[2];
    xx = q30_mul(x, x); yy = q30_mul(y, y); zz = q30_mul(z, z);
    t4 = 4 * zz - xx - yy;
    for (int i = 0; i < 16; i++) b[i] = 0;
    b[0] = K_DC;
    if (degree_shadow >= 1) begin
      b[1] = -q30_mul(K_C1, y);
      b[2] = q30_mul(K_C1, z);
      b[3] = -q30_mul(K_C1, x);
    end
    if (degree_shadow >= 2) begin
      b[4] = q30_mul(K_C2A, q30_mul(x, y));
      b[5] = -q30_mul(K_C2A, q30_mul(y, z));
      b[6] = q30_mul(K_C2C, 2 * zz - xx - yy);
      b[7] = -q30_mul(K_C2A, q30_mul(x, z));
      b[8] = q30_mul(K_C2E, xx - yy);
    end
    if (degree_shadow == 3) begin
      b[9]  = -q30_mul(K_C3A, q30_mul(y, 3 * xx - yy));
      b[10] = q30_mul(K_C3B, q30_mul(q30_mul(x, y), z));
      b[11] = -q30_mul(K_C3C, q30_mul(y, t4));
      b[12] = q30_mul(K_C3D, q30_mul(z, 2 * zz - 3 * xx - 3 * yy));
      b[13] = -q30_mul(K_C3C, q30_mul(x, t4));
      b[14] = q30_mul(K_C3F, q30_mul(z, xx - yy));
      b[15] = -q30_mul(K_C3A, q30_mul(x, xx - 3 * yy));
    end
    for (int i = 0; i < 16; i++) begin
      w = '{idx: 4'(i), val: q30_to_q14(b[i]), err: 1'b0, last: (i == 15)};
      basis_queue.push_back(w);
    end
  endtask

  // Track the degree register, predict on input words, compare output words
  always @(posedge clk) begin
    sh_word_t w;
    if (!rst_n) begin
      degree_shadow <= 2'd3;
      fail_count    <= 0;
      basis_queue.delete();
    end else begin
      if (cfg_we) degree_shadow <= cfg_sh_degree;
      if (in_valid && in_ready) predict_basis(in_dir_x, in_dir_y, in_dir_z);
      if (out_valid && out_ready) begin
        if (basis_queue.size() == 0) begin
          $error("unexpected output word, index %0d", out_coef_index);
          fail_count <= fail_count + 1;
        end else begin
          w = basis_queue.pop_front();
          if (out_coef_index !== w.idx || out_basis_value !== w.val ||
              out_dir_error !== w.err || out_last !== w.last) begin
            fail_count <= fail_count + 1;
            if (out_coef_index !== w.idx)
              $error("coef_index: expected %0d, actual %0d", w.idx, out_coef_index);
            if (out_basis_value !== w.val)
              $error("basis_value: expected %0d, actual %0d",
                     $signed(w.val), out_basis_value);
            if (out_dir_error !== w.err)
              $error("dir_error: expected %0b, actual %0b", w.err, out_dir_error);
            if (out_last !== w.last)
              $error("last: expected %0b, actual %0b", w.last, out_last);
          end
        end
      end
    end
  end

endmodule

/* tb/testbench.sv */
// Top of the SH basis testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;

  localparam int RANDOM_DIRS = 140;
  localparam int HOLD_DIRS = 60;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 100;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_sh_degree = 2'd0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [15:0] in_dir_x = '0;
  logic signed [15:0] in_dir_y = '0;
  logic signed [15:0] in_dir_z = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [3:0]         out_coef_index;
  logic signed [15:0] out_basis_value;
  logic               out_dir_error;
  logic               out_last;
  int                 fail_count;
  int                 pending_words;
  int                 cycle_count = 0;
  logic               calm_phase = 1'b0;
  logic               hold_off = 1'b0;

  always #6 clk = ~clk;

  sh_basis_degree3_eval u_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_sh_degree(cfg_sh_degree),
    .in_valid(in_valid), .in_ready(in_ready), .in_dir_x(in_dir_x),
    .in_dir_y(in_dir_y), .in_dir_z(in_dir_z), .out_valid(out_valid),
    .out_ready(out_ready), .out_coef_index(out_coef_index),
    .out_basis_value(out_basis_value), .out_dir_error(out_dir_error),
    .out_last(out_last)
  );

  sh_basis_checker u_checker (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_sh_degree(cfg_sh_degree),
    .in_valid(in_valid), .in_ready(in_ready), .in_dir_x(in_dir_x),
    .in_dir_y(in_dir_y), .in_dir_z(in_dir_z), .out_valid(out_valid),
    .out_ready(out_ready), .out_coef_index(out_coef_index),
    .out_basis_value(out_basis_value), .out_dir_error(out_dir_error),
    .out_last(out_last), .fail_count(fail_count), .pending_words(pending_words)
  );

  // Abort on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver: random stall bursts, one long hold-off, steady near the end
  initial begin
    int burst;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        out_ready <= 1'b1;
        wait (!hold_off);
      end else if (!calm_phase && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 10);
        out_ready <= 1'b0;
        repeat (burst) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  // Offer one word and hold it until accepted
  task automatic send_dir(logic signed [15:0] dx, logic signed [15:0] dy,
                          logic signed [15:0] dz);
    if (!calm_phase && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_dir_x <= dx;
    in_dir_y <= dy;
    in_dir_z <= dz;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drain, let the pipeline settle, then write the degree
  task automatic set_degree(logic [1:0] deg);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we        <= 1'b1;
    cfg_sh_degree <= deg;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [15:0] rand_comp();
    case ($urandom_range(0, 3))
      0: return 16'($signed($urandom_range(0, 15)) - 8);
      1: return 16'(($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero vector, axes, extremes, tiny vectors
    send_dir(0, 0, 0);
    send_dir(16'sh7fff, 0, 0);
    send_dir(16'sh8000, 0, 0);
    send_dir(0, 16'sh7fff, 0);
    send_dir(0, 16'sh8000, 0);
    send_dir(0, 0, 16'sh7fff);
    send_dir(0, 0, 16'sh8000);
    send_dir(16'sh8000, 16'sh8000, 16'sh8000);
    send_dir(16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_dir(1, 1, 1);
    send_dir(-1, 1, -1);
    send_dir(1, 0, 0);
    send_dir(16'sh7fff, 16'sh8000, 1);
    send_dir(0, 0, 0);
    send_dir(-1, -1, -1);
    send_dir(3, -4, 0);
    send_dir(16'h5555, 16'shaaaa, 16'sh1234);

    // Long receiver hold-off while directions keep coming
    hold_off = 1'b1;
    for (int i = 0; i < HOLD_DIRS; i++) send_dir(rand_comp(), rand_comp(), rand_comp());
    hold_off = 1'b0;

    // Random directions across every degree setting
    for (int ph = 0; ph < 5; ph++) begin
      set_degree(ph == 4 ? 2'd3 : 2'(ph));
      if (ph == 4) calm_phase = 1'b1;
      for (int i = 0; i < RANDOM_DIRS / 5; i++) begin
        if ($urandom_range(0, 30) == 0) send_dir(0, 0, 0);
        else send_dir(rand_comp(), rand_comp(), rand_comp());
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
